FILE: hdl/mpc_pkg.sv
// Shared types, constants and arithmetic helpers of the mip chain generator.
`default_nettype none
package mpc_pkg;

   localparam int MAX_SIZE   = 2048;
   localparam int MAX_LEVELS = 12;
   localparam int MIN_SIZE   = 96;
   localparam int SIDE_W     = 12;
   localparam int COORD_W    = 11;
   localparam int LEVEL_W    = 4;
   localparam int ADDR_W     = $clog2(MAX_SIZE);
   localparam int PAIR_W     = 36;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] mip_level;
      logic [COORD_W-1:0] texel_col;
      logic [COORD_W-1:0] texel_row;
      logic [7:0]         out_red;
      logic [7:0]         out_green;
      logic [7:0]         out_blue;
      logic [7:0]         out_alpha;
      logic               run_last;
      logic               chain_done;
   } rsp_type;

   // Pixel handed from the multiply stage to the level engine.
   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [15:0]        red_prod;
      logic [15:0]        green_prod;
      logic [15:0]        blue_prod;
      logic [7:0]         alpha;
   } pix_type;

   // floor((prod + 127) / 255) by reciprocal with correction.
   function automatic logic [7:0] premul_div(input logic [15:0] prod);
      logic [16:0] y;
      logic [16:0] q;
      y = {1'b0, prod} + 17'd127;
      q = y + 17'd1 + (y >> 8);
      return q[15:8];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/premultiplied_mip_chain_generator.sv
// Top level of the premultiplied box-filter mip chain generator.
`default_nettype none
// Takes RGBA8 pixels of a square image in raster order over req_, premultiplies color
// by alpha as (c*a+127)/255 and returns each pixel at once as a level-0 texel, followed
// by every lower-level texel that pixel completes (2x2 box filter, (sum+2)/4, built from
// the rounded level above). Texels come out on rsp_ tagged with level and position, so
// levels interleave; run_last marks the last texel of a pixel and chain_done the 1x1
// texel. Each texel passes through two states of the level engine, one to read the pair-sum
// RAM and one to combine and emit; a pixel holds the engine until it and every lower-level
// texel it completes are emitted, and the next pixel loads as its last texel is emitted.
// The input stage holds one pixel ahead of the engine and the output register
// parts the engine from rsp_ready. image_size (address 0, 12 bits) is clamped to
// 96..2048 and a write restarts at pixel (0,0); write it only while the block is idle.
module premultiplied_mip_chain_generator (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mpc_pkg::req_type     req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mpc_pkg::rsp_type          rsp_data,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import mpc_pkg::*;

   localparam logic REG_IMAGE_SIZE = 1'b0;

   logic [SIDE_W-1:0] size_ff, size_in;
   logic [SIDE_W-1:0] side;
   logic              cfg_wr;
   logic              pix_valid, pix_ready;
   pix_type           pix_data;

   // Register write completes on the access phase; only index 0 exists, decoded from paddr[2] alone.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IMAGE_SIZE);
   assign size_in = cfg_wr ? pwdata[SIDE_W-1:0] : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIDE_W'(MIN_SIZE);
      end else begin
         size_ff <= size_in;
      end
   end

   assign prdata = (paddr[2] == REG_IMAGE_SIZE) ? {{(32-SIDE_W){1'b0}}, size_ff} : '0;

   // Clamp the side to the supported range.
   always_comb begin
      if (size_ff < SIDE_W'(MIN_SIZE)) begin
         side = SIDE_W'(MIN_SIZE);
      end else if (size_ff > SIDE_W'(MAX_SIZE)) begin
         side = SIDE_W'(MAX_SIZE);
      end else begin
         side = size_ff;
      end
   end

   mpc_premul u_premul (
      .clock     (clock),
      .reset     (reset),
      .restart   (cfg_wr),
      .side      (side),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_data  (pix_data)
   );

   mpc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .side      (side),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix_data  (pix_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: hdl/mpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: hdl/mpc_premul.sv
// Input stage: raster position tracking and color-by-alpha products.
`default_nettype none
module mpc_premul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [mpc_pkg::SIDE_W-1:0]    side,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire mpc_pkg::req_type              req_data,
   output logic                               pix_valid,
   input  wire logic                          pix_ready,
   output mpc_pkg::pix_type                   pix_data
);
   import mpc_pkg::*;

   logic                  v_ff, v_in;
   pix_type               pix_ff, pix_in;
   logic [COORD_W-1:0]    col_ff, col_in, row_ff, row_in;
   logic [SIDE_W-1:0]     col_next, row_next;
   logic                  take;

   assign req_ready = !v_ff || pix_ready;
   assign take      = req_valid && req_ready;
   assign col_next  = {1'b0, col_ff} + SIDE_W'(1);
   assign row_next  = {1'b0, row_ff} + SIDE_W'(1);

   always_comb begin
      v_in   = v_ff;
      pix_in = pix_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (pix_ready) begin
         v_in = 1'b0;
      end
      if (take) begin
         v_in              = 1'b1;
         pix_in.col        = col_ff;
         pix_in.row        = row_ff;
         pix_in.red_prod   = req_data.in_red   * req_data.in_alpha;
         pix_in.green_prod = req_data.in_green * req_data.in_alpha;
         pix_in.blue_prod  = req_data.in_blue  * req_data.in_alpha;
         pix_in.alpha      = req_data.in_alpha;
         // Advance the raster position, wrap at the end of the image.
         if (col_next >= side) begin
            col_in = '0;
            row_in = (row_next >= side) ? '0 : row_next[COORD_W-1:0];
         end else begin
            col_in = col_next[COORD_W-1:0];
         end
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         v_ff   <= v_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
      pix_ff <= pix_in;
   end

   assign pix_valid = v_ff;
   assign pix_data  = pix_ff;
endmodule
`default_nettype wire

FILE: hdl/mpc_engine.sv
// Level engine: walks one pixel down the mip chain through the pair-sum RAM.
`default_nettype none
module mpc_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [mpc_pkg::SIDE_W-1:0]    side,
   input  wire logic                          pix_valid,
   output logic                               pix_ready,
   input  wire mpc_pkg::pix_type              pix_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output mpc_pkg::rsp_type                   rsp_data
);
   import mpc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [LEVEL_W-1:0]  lvl_ff, lvl_in;
   logic [COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [SIDE_W-1:0]   side_ff, side_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [31:0]         tex_ff, tex_in;
   logic [31:0]         held_ff [MAX_LEVELS];
   logic                out_v_ff, out_v_in;
   rsp_type             out_ff, out_in;

   logic [SIDE_W-1:0]   half;
   logic [COORD_W-1:0]  hx, hy;
   logic [ADDR_W-1:0]   idx;
   logic                can_go, cont, slot_free, fire, load;
   logic [31:0]         held_rd, next_tex;
   logic [PAIR_W-1:0]   pairs, above;
   logic                held_we, ram_we;

   assign half    = side_ff >> 1;
   assign hx      = x_ff >> 1;
   assign hy      = y_ff >> 1;
   assign idx     = base_ff + ADDR_W'(hx);
   assign can_go  = (side_ff >= SIDE_W'(2)) && (lvl_ff < LEVEL_W'(MAX_LEVELS - 1))
                    && ({1'b0, hx} < half) && ({1'b0, hy} < half);
   assign cont    = can_go && x_ff[0] && y_ff[0];
   assign held_rd = held_ff[lvl_ff];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic [8:0]  pr;
         logic [10:0] sum;
         pr  = {1'b0, held_rd[8*c +: 8]} + {1'b0, tex_ff[8*c +: 8]};
         sum = {2'b00, above[9*c +: 9]} + {2'b00, pr} + 11'd2;
         pairs[9*c +: 9]    = pr;
         next_tex[8*c +: 8] = sum[9:2];
      end
   end

   assign slot_free = !out_v_ff || rsp_ready;
   assign fire      = (state_ff == ST_EMIT) && slot_free;
   assign load      = pix_valid && ((state_ff == ST_IDLE) || (fire && !cont));
   assign pix_ready = load;
   assign held_we   = fire && can_go && !x_ff[0];
   assign ram_we    = fire && can_go && x_ff[0] && !y_ff[0];

   // Rows of one level are written on even rows and read on the next odd row,
   // a full row of pixels later, so read and write never collide.
   mpc_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_SIZE)) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data (pairs),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (idx),
      .rd_data (above)
   );

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      side_in  = side_ff;
      base_in  = base_ff;
      tex_in   = tex_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_in   = out_ff;
      unique case (state_ff)
         ST_IDLE: ;
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (fire) begin
               out_v_in          = 1'b1;
               out_in.mip_level  = lvl_ff;
               out_in.texel_col  = x_ff;
               out_in.texel_row  = y_ff;
               out_in.out_red    = tex_ff[7:0];
               out_in.out_green  = tex_ff[15:8];
               out_in.out_blue   = tex_ff[23:16];
               out_in.out_alpha  = tex_ff[31:24];
               out_in.run_last   = !cont;
               out_in.chain_done = (side_ff == SIDE_W'(1));
               if (cont) begin
                  state_in = ST_READ;
                  tex_in   = next_tex;
                  base_in  = base_ff + half[ADDR_W-1:0];
                  lvl_in   = lvl_ff + LEVEL_W'(1);
                  x_in     = hx;
                  y_in     = hy;
                  side_in  = half;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (load) begin
         state_in = ST_READ;
         lvl_in   = '0;
         x_in     = pix_data.col;
         y_in     = pix_data.row;
         side_in  = side;
         base_in  = '0;
         tex_in   = {pix_data.alpha, premul_div(pix_data.blue_prod),
                     premul_div(pix_data.green_prod), premul_div(pix_data.red_prod)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         lvl_ff   <= lvl_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      side_ff <= side_in;
      base_ff <= base_in;
      tex_ff  <= tex_in;
      out_ff  <= out_in;
      if (held_we) begin
         held_ff[lvl_ff] <= tex_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   a_level_step: assert property (@(posedge clock) disable iff (reset)
      fire && cont |=> (lvl_ff == $past(lvl_ff) + LEVEL_W'(1)) && (state_ff == ST_READ))
      else $error("level did not advance after a continuing emit");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff < LEVEL_W'(MAX_LEVELS))
      else $error("level beyond chain depth");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.chain_done |-> out_ff.run_last)
      else $error("final texel not marked last of its run");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (state_ff == ST_IDLE) || !cont)
      else $error("pixel loaded while chain still running");
endmodule
`default_nettype wire
